@@ hdl/tachometer_period_to_rpm_defines.svh @@
// Assertion macros shared by the tachometer period-to-rpm RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef TACHOMETER_PERIOD_TO_RPM_DEFINES_SVH
`define TACHOMETER_PERIOD_TO_RPM_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define TPR_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tachometer invariant violated");

// A condition that must hold in the cycle after a trigger.
`define TPR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tachometer sequencing violated");

`endif

@@ hdl/tprpm_pkg.sv @@
// Shared types and constants for the tachometer period-to-rpm block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tprpm_pkg;

    localparam int RPM_BITS      = 16;
    localparam int OUT_ACC_BITS  = 17;
    localparam int PROD_BITS     = OUT_ACC_BITS + RPM_BITS;
    localparam int CFG_ADDR_BITS = 4;

    // 60000 rpm-ms: one revolution per millisecond period.
    localparam logic [RPM_BITS-1:0] RPM_NUMERATOR = 16'd60000;
    localparam logic [RPM_BITS-1:0] RPM_SATURATED = 16'd60000;

    localparam logic [1:0] REG_WARN_HIGH   = 2'd0;
    localparam logic [1:0] REG_WARN_LOW    = 2'd1;
    localparam logic [1:0] REG_PULSE_RATIO = 2'd2;

    localparam logic [15:0] WARN_HIGH_RESET   = 16'd7000;
    localparam logic [15:0] WARN_LOW_RESET    = 16'd6500;
    localparam logic [31:0] PULSE_RATIO_RESET = 32'd60000;

    typedef struct packed {
        logic        pulse_level;
        logic [15:0] elapsed_ms;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] rpm_value;
        logic        overspeed_warning;
        logic        out_level;
        logic        edge_seen;
    } out_beat_t;

    typedef struct packed {
        logic [15:0] warn_high_rpm;
        logic [15:0] warn_low_rpm;
        logic [31:0] pulse_ratio;
    } cfg_t;

endpackage

@@ hdl/tachometer_period_to_rpm.sv @@
// Top level of the tachometer period-to-rpm converter.
// Depends on tprpm_pkg, tprpm_regs, tprpm_div and the assertion macro header.
`timescale 1ns / 1ps
`include "tachometer_period_to_rpm_defines.svh"

// Each input beat is one tick carrying the tach pin level and the milliseconds
// since the previous tick, and each tick yields exactly one output beat. A tick
// without a level change adds its time to the period and passes through the
// multiply and update steps; the result register loads in the update step,
// after which the block is ready again. A tick with a level change starts the
// restoring divider, which produces one bit of 60000 / period per cycle; when
// it is done the quotient is registered as the rpm, and the warning, multiply
// and update steps follow, the result register loading in the update step. An
// edge after zero accumulated time skips the divider and reports 60000 rpm,
// going through the warning, multiply and update steps. A result that has not
// yet been taken holds the sequencer in its last step until the output
// register is free. The block takes one tick at a time: in_ready is high only
// while the sequencer is idle, but a finished result may sit in the output
// register while the next tick is accepted. The warning sets at
// rpm >= warn_high_rpm and, failing that, clears at rpm <= warn_low_rpm. The
// regenerated output toggles when out_acc * rpm exceeds pulse_ratio; its
// accumulator, cleared on a toggle, then adds the tick time and wraps to zero
// above OUT_WRAP_MS. Configuration should only be written while idle.
module tachometer_period_to_rpm
    import tprpm_pkg::*;
#(
    parameter int OUT_WRAP_MS = 1000,
    parameter int PERIOD_BITS = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_beat_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_beat_t                out_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_WARN = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;

    localparam logic [OUT_ACC_BITS-1:0] WRAP_LIMIT = OUT_ACC_BITS'(OUT_WRAP_MS);

    cfg_t cfg;

    logic [2:0]              state_reg;
    logic                    last_level_reg;
    logic [PERIOD_BITS-1:0]  period_acc_reg;
    logic [RPM_BITS-1:0]     rpm_reg;
    logic                    warn_reg;
    logic [OUT_ACC_BITS-1:0] out_acc_reg;
    logic                    out_reg;
    logic [15:0]             elapsed_reg;
    logic                    edge_reg;
    logic [PROD_BITS-1:0]    prod_reg;
    logic                    out_valid_reg;
    out_beat_t               out_data_reg;

    logic                    in_fire;
    logic                    level_change;
    logic [PERIOD_BITS:0]    period_sum;
    logic [PERIOD_BITS-1:0]  period_next;
    logic                    div_start;
    logic                    div_done;
    logic [RPM_BITS-1:0]     div_quotient;
    logic                    toggle;
    logic [OUT_ACC_BITS-1:0] acc_base;
    logic [OUT_ACC_BITS-1:0] acc_sum;
    logic [OUT_ACC_BITS-1:0] out_acc_next;
    logic                    out_next;
    logic                    result_load;

    tprpm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tprpm_div #(
        .DW (PERIOD_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (RPM_NUMERATOR),
        .divisor  (period_acc_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_fire      = in_valid & in_ready;
    assign level_change = (in_data.pulse_level != last_level_reg);
    assign div_start    = in_fire & level_change & (period_acc_reg != '0);

    // Saturating period accumulation; the carry out marks overflow.
    always_comb
    begin
        period_sum  = {1'b0, period_acc_reg}
                    + {{(PERIOD_BITS - 15){1'b0}}, in_data.elapsed_ms};
        period_next = period_sum[PERIOD_BITS] ? {PERIOD_BITS{1'b1}}
                                              : period_sum[PERIOD_BITS-1:0];
    end

    // Output pulse regeneration: compare the registered product, clear on a
    // toggle, add the tick time and wrap above the limit.
    always_comb
    begin
        toggle       = (prod_reg > {1'b0, cfg.pulse_ratio});
        acc_base     = toggle ? '0 : out_acc_reg;
        acc_sum      = acc_base + OUT_ACC_BITS'(elapsed_reg);
        out_acc_next = (acc_sum > WRAP_LIMIT) ? '0 : acc_sum;
        out_next     = out_reg ^ toggle;
    end

    assign result_load = (state_reg == ST_UPD) & (~out_valid_reg | out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_level_reg <= 1'b0;
            period_acc_reg <= '0;
            rpm_reg        <= '0;
            warn_reg       <= 1'b0;
            out_acc_reg    <= '0;
            out_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // A new result replaces one that leaves in the same cycle.
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (level_change)
                        begin
                            last_level_reg <= in_data.pulse_level;
                            period_acc_reg <= '0;
                            if (period_acc_reg == '0)
                            begin
                                rpm_reg   <= RPM_SATURATED;
                                state_reg <= ST_WARN;
                            end
                            else
                            begin
                                state_reg <= ST_DIV;
                            end
                        end
                        else
                        begin
                            period_acc_reg <= period_next;
                            state_reg      <= ST_MUL;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        rpm_reg   <= div_quotient;
                        state_reg <= ST_WARN;
                    end
                end
                ST_WARN:
                begin
                    // Set has priority over clear when both thresholds are met.
                    if (rpm_reg >= cfg.warn_high_rpm)
                    begin
                        warn_reg <= 1'b1;
                    end
                    else if (rpm_reg <= cfg.warn_low_rpm)
                    begin
                        warn_reg <= 1'b0;
                    end
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (result_load)
                    begin
                        out_acc_reg <= out_acc_next;
                        out_reg     <= out_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            elapsed_reg <= in_data.elapsed_ms;
            edge_reg    <= level_change;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_BITS'(out_acc_reg) * PROD_BITS'(rpm_reg);
        end
        if (result_load)
        begin
            out_data_reg.rpm_value         <= rpm_reg;
            out_data_reg.overspeed_warning <= warn_reg;
            out_data_reg.out_level         <= out_next;
            out_data_reg.edge_seen         <= edge_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `TPR_ASSERT_ALWAYS(a_rpm_in_range, rpm_reg <= RPM_SATURATED)
    `TPR_ASSERT_ALWAYS(a_out_acc_wrapped, out_acc_reg <= WRAP_LIMIT)
    `TPR_ASSERT_ALWAYS(a_div_done_in_div, !div_done || state_reg == ST_DIV)
    `TPR_ASSERT_NEXT(a_edge_clears_period, in_fire && level_change, period_acc_reg == '0)

endmodule

@@ hdl/tprpm_regs.sv @@
// APB-style configuration registers of the tachometer block.
// Depends on tprpm_pkg for the register indexes and reset values.
`timescale 1ns / 1ps

module tprpm_regs
    import tprpm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warn_high_rpm <= WARN_HIGH_RESET;
            cfg_reg.warn_low_rpm  <= WARN_LOW_RESET;
            cfg_reg.pulse_ratio   <= PULSE_RATIO_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_WARN_HIGH:   cfg_reg.warn_high_rpm <= pwdata[15:0];
                REG_WARN_LOW:    cfg_reg.warn_low_rpm  <= pwdata[15:0];
                REG_PULSE_RATIO: cfg_reg.pulse_ratio   <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WARN_HIGH:   prdata = {16'd0, cfg_reg.warn_high_rpm};
            REG_WARN_LOW:    prdata = {16'd0, cfg_reg.warn_low_rpm};
            REG_PULSE_RATIO: prdata = cfg_reg.pulse_ratio;
            default:         prdata = 32'd0;
        endcase
    end

endmodule

@@ hdl/tprpm_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tprpm_pkg for the quotient width.
`timescale 1ns / 1ps

module tprpm_div
    import tprpm_pkg::*;
#(
    parameter int DW = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [RPM_BITS-1:0] dividend,
    input  logic [DW-1:0]       divisor,
    output logic                done,
    output logic [RPM_BITS-1:0] quotient
);

    localparam int CW = $clog2(RPM_BITS);

    logic [DW-1:0]       div_reg;
    logic [DW-1:0]       rem_reg;
    logic [RPM_BITS-1:0] quo_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          qbit;
    logic [DW-1:0] rem_next;

    // The remainder stays below the divisor, so a failed subtract fits DW bits.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[RPM_BITS-1]};
        diff     = shifted - {1'b0, div_reg};
        qbit     = ~diff[DW];
        rem_next = qbit ? diff[DW-1:0] : shifted[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RPM_BITS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[RPM_BITS-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
